[sv/acsx_pkg.sv]
// Package for the AES counter-mode keystream block: types, constants and the
// AES byte functions. No dependencies.
`timescale 1ns / 1ps
package acsx_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KLEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX = 3'd6;

    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;

    localparam logic [7:0] RCON_POLY = 8'h1b;

    // One request as it travels through the queue.
    typedef struct packed {
        logic       restart;
        logic [4:0] byte_count;
    } req_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? RCON_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ x;
            x = xtime(x);
        end
        gf_mul = acc;
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] x2, x3, x6, x12, x15, x30, x60, x120, x126, x127, inv;
        x2   = gf_mul(x, x);
        x3   = gf_mul(x2, x);
        x6   = gf_mul(x3, x3);
        x12  = gf_mul(x6, x6);
        x15  = gf_mul(x12, x3);
        x30  = gf_mul(x15, x15);
        x60  = gf_mul(x30, x30);
        x120 = gf_mul(x60, x60);
        x126 = gf_mul(x120, x6);
        x127 = gf_mul(x126, x);
        inv  = gf_mul(x127, x127);
        sbox_calc = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                  ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    // Constant S-box table, built at elaboration.
    typedef logic [7:0] sbox_arr_t [256];
    function automatic sbox_arr_t sbox_build();
        sbox_arr_t t;
        for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
        return t;
    endfunction
    localparam sbox_arr_t SBOX = sbox_build();

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // One round on a 128-bit state, byte j at bits 8j+7:8j.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c+r] = SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (mix) begin
                o[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
                o[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
                o[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                o[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end else begin
                o[8*(4*c)   +: 8] = a0;
                o[8*(4*c+1) +: 8] = a1;
                o[8*(4*c+2) +: 8] = a2;
                o[8*(4*c+3) +: 8] = a3;
            end
        end
        aes_round = o;
    endfunction

endpackage

[sv/acsx_front.sv]
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on acsx_pkg.
`timescale 1ns / 1ps
module acsx_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  acsx_pkg::req_t  in_req,
    output logic            q_valid,
    input  logic            q_ready,
    output acsx_pkg::req_t  q_req
);
    acsx_pkg::req_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= in_req;
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[sv/acsx_back.sv]
// Back end: key expansion, round sequencer and output register.
// Depends on acsx_pkg.
`timescale 1ns / 1ps
module acsx_back #(
    parameter int MAX_ROUNDS = 14
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  acsx_pkg::req_t  q_req,
    input  logic [63:0]     key0,
    input  logic [63:0]     key1,
    input  logic [63:0]     key2,
    input  logic [63:0]     key3,
    input  logic [1:0]      klen,
    input  logic            reduced,
    input  logic [7:0]      prefix,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [63:0]     out_low,
    output logic [63:0]     out_high,
    output logic [4:0]      out_count
);
    localparam int NWORDS = 4 * (MAX_ROUNDS + 1);
    localparam int WIDX_W = $clog2(NWORDS + 1);
    localparam int RND_W  = $clog2(MAX_ROUNDS + 1);
    localparam int RK_W   = $clog2(MAX_ROUNDS + 1);
    localparam logic [1:0] KLEN_SAT = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXP  = 4'b0010,
        ST_RND  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Round key memory: one 128-bit round key per row, one row a cycle.
    logic [127:0] rk_mem [MAX_ROUNDS + 1];
    logic [127:0] rk_rd_reg;
    logic [RK_W-1:0] rk_addr;

    // Expansion keeps the last eight words in a sliding window.
    logic [31:0]       win_reg [8];
    logic [WIDX_W-1:0] widx_reg;
    logic [3:0]        nk_reg;
    logic [3:0]        imod_reg;
    logic [7:0]        rcon_reg;
    logic [1:0]        wsub_reg;       // words of the current row already made
    logic [127:0]      row_reg;
    logic [WIDX_W-1:0] total;
    logic [31:0]       new_word, tmp;

    logic [63:0]  ctr_reg;
    logic         ready_reg;
    // Set once an expansion has finished for the request at the queue head.
    logic         exp_done_reg;
    logic         restart_pending;
    logic [4:0]   n_reg;
    logic [127:0] st_reg;
    logic [RND_W-1:0] rnd_reg, rounds;
    logic [1:0]   kmode;

    function automatic logic [127:0] aes_round_k(input logic [127:0] s, input logic m);
        aes_round_k = acsx_pkg::aes_round(s, m);
    endfunction
    function automatic logic [7:0] xtime_k(input logic [7:0] a);
        xtime_k = acsx_pkg::xtime(a);
    endfunction
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = acsx_pkg::sub_word(w);
    endfunction

    assign kmode = (klen == KLEN_SAT) ? 2'd2 : klen;

    always_comb begin
        logic [4:0] r;
        r = reduced ? 5'd4 : (5'd10 + {2'b0, kmode, 1'b0});
        if (r > 5'(MAX_ROUNDS)) r = 5'(MAX_ROUNDS);
        rounds = RND_W'(r);
    end

    always_comb begin
        logic [5:0] t;
        t = 6'd4 * (6'(nk_reg) + 6'd7);
        total = (t > 6'(NWORDS)) ? WIDX_W'(NWORDS) : WIDX_W'(t);
    end

    // Next schedule word from the window (win_reg[0] is w[i-1]).
    always_comb begin
        tmp = win_reg[0];
        if (imod_reg == 4'd0)
            tmp = sub_word({tmp[7:0], tmp[31:8]}) ^ {24'h0, rcon_reg};
        else if (nk_reg > 4'd6 && imod_reg == 4'd4)
            tmp = sub_word(tmp);
        new_word = win_reg[3'(nk_reg - 4'd1)] ^ tmp;
        if (widx_reg < WIDX_W'(nk_reg)) begin
            case (widx_reg[2:0])
                3'd0: new_word = key0[31:0];
                3'd1: new_word = key0[63:32];
                3'd2: new_word = key1[31:0];
                3'd3: new_word = key1[63:32];
                3'd4: new_word = key2[31:0];
                3'd5: new_word = key2[63:32];
                3'd6: new_word = key3[31:0];
                default: new_word = key3[63:32];
            endcase
        end
        if (widx_reg >= total) new_word = 32'h0;
    end

    assign restart_pending = (q_req.restart && !exp_done_reg) || !ready_reg;
    assign q_ready = (state_reg == ST_IDLE) && q_valid && !restart_pending;
    assign out_valid = (state_reg == ST_OUT);

    always_comb begin
        rk_addr = '0;
        if (state_reg == ST_IDLE) rk_addr = '0;
        else rk_addr = RK_W'(rnd_reg + 1'b1);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = restart_pending ? ST_EXP : ST_RND;
            ST_EXP:  if (widx_reg == WIDX_W'(NWORDS - 1)) state_next = ST_IDLE;
            ST_RND:  if (rnd_reg == rounds) state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        rk_rd_reg <= rk_mem[rk_addr];
        if (state_reg == ST_EXP) begin
            for (int k = 7; k > 0; k--) win_reg[k] <= win_reg[k-1];
            win_reg[0] <= new_word;
            row_reg[32*wsub_reg +: 32] <= new_word;
            if (wsub_reg == 2'd3)
                rk_mem[RK_W'(widx_reg >> 2)] <= {new_word, row_reg[95:0]};
        end
        if (q_ready) begin
            n_reg  <= (q_req.byte_count > 5'd16) ? 5'd16 : q_req.byte_count;
            st_reg <= {56'h0, prefix, ctr_reg};
        end else if (state_reg == ST_RND) begin
            if (rnd_reg == '0)
                st_reg <= st_reg ^ rk_rd_reg;
            else
                st_reg <= aes_round_k(st_reg, rnd_reg != rounds) ^ rk_rd_reg;
        end
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ready_reg    <= 1'b0;
            exp_done_reg <= 1'b0;
            ctr_reg      <= 64'h0;
            rnd_reg      <= '0;
            widx_reg     <= '0;
            wsub_reg     <= '0;
            imod_reg     <= '0;
            nk_reg       <= 4'd4;
            rcon_reg     <= 8'h01;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && q_valid && restart_pending) begin
                widx_reg <= '0;
                wsub_reg <= '0;
                imod_reg <= '0;
                rcon_reg <= 8'h01;
                nk_reg   <= 4'd4 + {1'b0, kmode, 1'b0};
                ctr_reg  <= 64'h0;
            end
            if (state_reg == ST_EXP) begin
                widx_reg <= widx_reg + 1'b1;
                wsub_reg <= wsub_reg + 2'd1;
                if (widx_reg >= WIDX_W'(nk_reg) && imod_reg == 4'd0)
                    rcon_reg <= xtime_k(rcon_reg);
                imod_reg <= (imod_reg == nk_reg - 4'd1) ? 4'd0 : imod_reg + 4'd1;
                if (widx_reg == WIDX_W'(NWORDS - 1)) begin
                    ready_reg    <= 1'b1;
                    exp_done_reg <= 1'b1;
                end
            end
            if (q_ready) begin
                rnd_reg      <= '0;
                ctr_reg      <= ctr_reg + 64'd1;
                exp_done_reg <= 1'b0;
            end else if (state_reg == ST_RND) begin
                rnd_reg <= rnd_reg + 1'b1;
            end
        end
    end

    // Masked output.
    always_comb begin
        logic [127:0] m;
        for (int j = 0; j < 16; j++)
            m[8*j +: 8] = (5'(j) < n_reg) ? st_reg[8*j +: 8] : 8'h00;
        out_low   = m[63:0];
        out_high  = m[127:64];
        out_count = n_reg;
    end
endmodule

[sv/aes_ctr_seed_expander_top.sv]
// An accepted request runs through the rounds and then shows on m_tvalid; rounds is 4 when
// reduced, else 10, 12 or 14 for AES-128, AES-192 and AES-256.
// The back end takes no new request until the previous block has been taken, and its
// single shared round unit does one AES round per cycle.
// A restart, or the first request after reset, first runs a key expansion. Synchronous
// active-low reset clears the queue, counter and key-ready flag.
`timescale 1ns / 1ps
module aes_ctr_seed_expander_top #(
    parameter int MAX_ROUNDS = 14
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [4:0] byte_count, rest zero
    input  logic          s_tuser,   // [0] restart
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [135:0]  m_tdata,   // [63:0] stream_low, [127:64] stream_high,
                                     // [132:128] valid_bytes, rest zero
    input  logic          cfg_we,
    input  logic [2:0]    cfg_idx,
    input  logic [63:0]   cfg_data
);
    // Configuration registers, to be written only while the block is idle; the block itself does not enforce this.
    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [1:0]  klen_reg;
    logic        reduced_reg;
    logic [7:0]  prefix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg <= '0; key1_reg <= '0; key2_reg <= '0; key3_reg <= '0;
            klen_reg <= '0; reduced_reg <= 1'b0; prefix_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                acsx_pkg::REG_KEY0:   key0_reg <= cfg_data;
                acsx_pkg::REG_KEY1:   key1_reg <= cfg_data;
                acsx_pkg::REG_KEY2:   key2_reg <= cfg_data;
                acsx_pkg::REG_KEY3:   key3_reg <= cfg_data;
                acsx_pkg::REG_KLEN:   klen_reg <= cfg_data[1:0];
                acsx_pkg::REG_REDUCE: reduced_reg <= cfg_data[0];
                acsx_pkg::REG_PREFIX: prefix_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    acsx_pkg::req_t in_req, q_req;
    logic q_valid, q_ready;
    logic [63:0] lo, hi;
    logic [4:0] cnt;

    assign in_req.restart    = s_tuser;
    assign in_req.byte_count = s_tdata[4:0];

    // The front end accepts requests; the queue lets it run ahead of the rounds.
    acsx_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req,
        .q_valid, .q_ready, .q_req
    );

    // The back end expands keys and runs the rounds, one per cycle.
    acsx_back #(.MAX_ROUNDS(MAX_ROUNDS)) u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_req,
        .key0(key0_reg), .key1(key1_reg), .key2(key2_reg), .key3(key3_reg),
        .klen(klen_reg), .reduced(reduced_reg), .prefix(prefix_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_low(lo), .out_high(hi), .out_count(cnt)
    );

    assign m_tdata = {3'b000, cnt, hi, lo};
endmodule

[sv/acsx_checker.sv]
// Port checker for the keystream block, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module acsx_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[132:128] <= 5'd16)
        else $error("valid byte count above sixteen");
    a_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[132:128] <= 5'd8 |-> m_tdata[127:64] == 64'h0)
        else $error("high bytes not masked");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result after reset");
endmodule

bind aes_ctr_seed_expander_top acsx_checker u_chk (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata
);
